// ===== hw/rtl/lqr_pkg.sv =====
// Package for the gain-scheduled LQR torque block: sizes, constants, types and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps
package lqr_pkg;
  localparam int NUM_SETS    = 5;
  localparam int FRAC_BITS   = 16;
  localparam int GAINS       = 12;
  localparam int TERMS       = 4;
  localparam int SET_WORDS   = GAINS * TERMS;
  localparam int STORE_DEPTH = NUM_SETS * SET_WORDS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SET_W       = 3;
  localparam int LEN_BITS    = 16;
  localparam int LANES       = 2;
  localparam logic [31:0] STEP32 = 32'd1124419809;

  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  typedef struct packed {
    logic              command;
    logic signed [31:0] theta;
    logic signed [31:0] theta_rate;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] pitch;
    logic signed [31:0] pitch_rate;
    logic [15:0]       leg_length;
    logic [2:0]        load_set;
    logic [3:0]        load_gain;
    logic [1:0]        load_term;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] wheel_torque;
    logic signed [31:0] joint_torque;
    logic [2:0]        set_used;
    logic              clipped;
  } out_item_t;

  // lane control from the sequencer
  typedef struct packed {
    logic       clear;   // start a new item
    logic       gain_go; // gain word for this state element is complete
  } lane_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic is_sat(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction
endpackage

// ===== hw/rtl/lqr_if.sv =====
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on lqr_pkg.
`timescale 1ns / 1ps
interface lqr_in_if;
  import lqr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lqr_out_if;
  import lqr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/lqr_lane.sv =====
// One torque lane: evaluates one gain polynomial per state element and
// accumulates x*K. Depends on lqr_pkg.
`timescale 1ns / 1ps
module lqr_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  lqr_pkg::lane_ctl_t      ctl,
  input  logic                    term_vld,
  input  logic [1:0]              term,
  input  logic signed [31:0]      coef,
  input  logic [15:0]             lpow,
  input  logic signed [31:0]      x,
  output logic signed [63:0]      acc
);
  import lqr_pkg::*;
  logic signed [63:0] gain;
  logic signed [48:0] prod;
  logic signed [31:0] k;
  logic signed [63:0] xk;
  logic               xk_vld;

  assign prod = coef * $signed({1'b0, lpow});
  assign k    = sat32(gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      xk_vld <= 1'b0;
    end else begin
      xk_vld <= ctl.gain_go;
    end
    if (ctl.clear || ctl.gain_go) gain <= '0;
    else if (term_vld) begin
      if (term == 2'd3) gain <= gain + 64'(coef);
      else gain <= gain + 64'(prod >>> LEN_BITS);
    end
    if (ctl.gain_go) xk <= x * k;
    if (ctl.clear) acc <= '0;
    else if (xk_vld) acc <= acc + (xk >>> FRAC_BITS);
  end
endmodule

// ===== hw/rtl/lqr_gain_scheduled_torque.sv =====
// Top level of the gain-scheduled LQR torque block: coefficient memory,
// sequencer, two lanes and the merge stage. Depends on lqr_pkg, lqr_if, lqr_lane.
//
// Usage: one input channel (in_ch) takes load and compute transactions;
// one output channel (out_ch) returns one result per compute transaction.
// A load transaction writes one coefficient word and gives no
// result; loads are taken back to back while the block is idle.
// A compute transaction goes through these steps from acceptance to result:
// form L^2 and the set, then L^3; then 48 coefficient reads
// (6 state elements x 4 terms x 2 lanes) through the memory's single read
// port; then the drain state empties the lanes, and the last step
// saturates into the output register.
// A new transaction is taken only in the idle state, and only once the
// output register has been emptied.
// Reset clears control only; the coefficient memory holds whatever it held
// and must be loaded before use. When the receiver stalls the result holds
// in the output register and new transactions wait.
`timescale 1ns / 1ps
module lqr_gain_scheduled_torque (
  input logic clk,
  input logic rst,
  lqr_in_if.sink    in_ch,
  lqr_out_if.source out_ch
);
  import lqr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_POW = 3'd1, S_POW2 = 3'd2,
                         S_RUN = 3'd3, S_DRAIN = 3'd4, S_DONE = 3'd5;

  logic [2:0]  state;
  in_item_t    item;
  logic [15:0] l2, l3;
  logic [SET_W-1:0] set;
  logic [2:0]  elem;
  logic [1:0]  term;
  logic        lane;
  logic [2:0]  drain;
  logic [31:0] mem [STORE_DEPTH];
  logic [31:0] rdata;
  logic        rd_vld;
  logic [1:0]  rd_term;
  logic        rd_lane;
  logic        rd_last;
  logic signed [31:0] x_sel;
  logic [ADDR_W-1:0] raddr;
  logic [15:0] lpow;
  logic signed [63:0] acc [LANES];
  logic [31:0] mag;
  logic [33:0] twice;
  logic [SET_W-1:0] set_next;
  logic        accept;

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign accept = in_ch.valid && in_ch.ready;

  assign mag   = item.theta[31] ? 32'(-item.theta) : item.theta;
  always_comb begin
    twice = {mag, 1'b0, 1'b0} >> 1; // 2*|theta| in Q.16 units, 34 bits
    set_next = '0;
    for (int k = 1; k < NUM_SETS; k++) begin
      if ({twice, 32'(0)} >> (FRAC_BITS) >= 66'((2 * k - 1)) * 66'(STEP32))
        set_next = SET_W'(k);
    end
  end

  assign raddr = ADDR_W'(set * SET_WORDS + (elem * 2 + lane) * TERMS + term);

  always_ff @(posedge clk) begin
    if (accept && in_ch.data.command == CMD_LOAD && in_ch.data.load_set < NUM_SETS
        && in_ch.data.load_gain < GAINS)
      mem[ADDR_W'(in_ch.data.load_set * SET_WORDS + in_ch.data.load_gain * TERMS
          + in_ch.data.load_term)] <= in_ch.data.load_value;
    rdata <= mem[raddr];
  end

  always_comb begin
    unique case (elem)
      3'd0: x_sel = item.theta;
      3'd1: x_sel = item.theta_rate;
      3'd2: x_sel = item.position;
      3'd3: x_sel = item.velocity;
      3'd4: x_sel = item.pitch;
      default: x_sel = item.pitch_rate;
    endcase
    unique case (rd_term)
      2'd0: lpow = item.leg_length;
      2'd1: lpow = l2;
      default: lpow = l3;
    endcase
  end

  // x of the element whose gains are read; delay to match memory latency
  logic signed [31:0] x_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      rd_vld <= (state == S_RUN);
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          item <= in_ch.data;
          if (in_ch.data.command == CMD_COMPUTE) state <= S_POW;
        end
        S_POW: begin
          l2 <= 16'((32'(item.leg_length) * 32'(item.leg_length)) >> LEN_BITS);
          set <= set_next;
          state <= S_POW2;
        end
        S_POW2: begin
          l3 <= 16'((32'(l2) * 32'(item.leg_length)) >> LEN_BITS);
          elem <= '0; term <= '0; lane <= 1'b0;
          state <= S_RUN;
        end
        S_RUN: begin
          term <= term + 2'd1;
          if (term == 2'd3) begin
            lane <= ~lane;
            if (lane) begin
              if (elem == 3'd5) begin
                state <= S_DRAIN;
                drain <= '0;
              end else elem <= elem + 3'd1;
            end
          end
        end
        S_DRAIN: begin
          drain <= drain + 3'd1;
          if (drain == 3'd4) state <= S_DONE;
        end
        S_DONE: begin
          out_ch.data.wheel_torque <= sat32(acc[0]);
          out_ch.data.joint_torque <= sat32(acc[1]);
          out_ch.data.set_used <= set;
          out_ch.data.clipped <= is_sat(acc[0]) || is_sat(acc[1]);
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    rd_term <= term;
    rd_lane <= lane;
    rd_last <= (term == 2'd3);
    x_rd    <= x_sel;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    // gain completes the cycle after its last term is added
    logic go_d;
    lane_ctl_t lc;
    logic signed [31:0] x_hold;
    always_ff @(posedge clk) begin
      if (rst) go_d <= 1'b0;
      else go_d <= rd_vld && rd_last && (rd_lane == 1'(g));
    end
    always_ff @(posedge clk) x_hold <= x_rd;
    assign lc.clear   = (state == S_POW2);
    assign lc.gain_go = go_d;
    lqr_lane u_lane (
      .clk(clk), .rst(rst), .ctl(lc),
      .term_vld(rd_vld && (rd_lane == 1'(g))),
      .term(rd_term), .coef(rdata), .lpow(lpow), .x(x_hold), .acc(acc[g])
    );
  end
endmodule

// ===== hw/rtl/lqr_checker.sv =====
// Port-level checker for the LQR torque block, bound to the top level.
// Depends on lqr_pkg.
`timescale 1ns / 1ps
module lqr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] set_used
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> set_used < 3'd5) else $error("set out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("valid after reset");
endmodule

bind lqr_gain_scheduled_torque lqr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .set_used(out_ch.data.set_used)
);

// ===== tb/sv/lqr_tb_if.sv =====
// Testbench-side note: the block's channel interfaces live in hw/rtl/lqr_if.sv.
// This file holds no extra interface, only the scoreboard package; the testbench uses lqr_in_if and lqr_out_if.
`timescale 1ns / 1ps
package lqr_tb_pkg;
  import lqr_pkg::*;

  // Expected torques per compute transaction; holds its own copy of the store.
  class torque_scoreboard;
    logic [31:0] coef [STORE_DEPTH];
    out_item_t   pending[$];
    int          errors;

    function new();
      errors = 0;
      foreach (coef[i]) coef[i] = '0;
    endfunction

    function automatic longint fdiv(longint v, int n);
      return v >>> n;
    endfunction

    function automatic logic [2:0] choose_set(logic signed [31:0] th);
      longint mag;
      longint twice;
      logic [2:0] s;
      mag = th;
      if (mag < 0) mag = -mag;
      twice = mag << (32 - FRAC_BITS + 1);
      s = '0;
      for (int k = 1; k < NUM_SETS; k++)
        if (twice >= longint'(2 * k - 1) * longint'(STEP32)) s = 3'(k);
      return s;
    endfunction

    function automatic longint clamp(longint v, ref bit hit);
      if (v > 64'sd2147483647) begin
        hit = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        hit = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function void note_input(in_item_t it);
      longint x[6];
      longint lp[3];
      longint acc[2];
      longint g;
      logic [2:0] s;
      bit clip;
      bit ign;
      out_item_t r;
      int base;
      if (it.command == CMD_LOAD) begin
        if (it.load_set < NUM_SETS && it.load_gain < GAINS)
          coef[it.load_set * SET_WORDS + it.load_gain * TERMS + it.load_term] = it.load_value;
        return;
      end
      x[0] = it.theta; x[1] = it.theta_rate; x[2] = it.position;
      x[3] = it.velocity; x[4] = it.pitch; x[5] = it.pitch_rate;
      lp[0] = it.leg_length;
      lp[1] = (lp[0] * lp[0]) >>> LEN_BITS;
      lp[2] = (lp[1] * lp[0]) >>> LEN_BITS;
      s = choose_set(it.theta);
      acc[0] = 0; acc[1] = 0; clip = 0; ign = 0;
      for (int i = 0; i < 6; i++)
        for (int j = 0; j < 2; j++) begin
          base = s * SET_WORDS + (i * 2 + j) * TERMS;
          g = longint'(signed'(coef[base + 3]));
          for (int t = 0; t < 3; t++)
            g += fdiv(longint'(signed'(coef[base + t])) * lp[t], LEN_BITS);
          g = clamp(g, ign);
          acc[j] += fdiv(x[i] * g, FRAC_BITS);
        end
      r.wheel_torque = 32'(clamp(acc[0], clip));
      r.joint_torque = 32'(clamp(acc[1], clip));
      r.set_used = s;
      r.clipped = clip;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result wheel=%0h joint=%0h", got.wheel_torque, got.joint_torque);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.wheel_torque !== e.wheel_torque) begin
        $error("wheel_torque exp %0h got %0h", e.wheel_torque, got.wheel_torque); errors++;
      end
      if (got.joint_torque !== e.joint_torque) begin
        $error("joint_torque exp %0h got %0h", e.joint_torque, got.joint_torque); errors++;
      end
      if (got.set_used !== e.set_used) begin
        $error("set_used exp %0d got %0d", e.set_used, got.set_used); errors++;
      end
      if (got.clipped !== e.clipped) begin
        $error("clipped exp %0d got %0d", e.clipped, got.clipped); errors++;
      end
    endfunction
  endclass
endpackage

// ===== tb/sv/lqr_gain_scheduled_torque_test.sv =====
// Top of the torque block testbench: loads coefficient sets, then drives
// directed and random compute transactions, with random loads mixed in, and checks each result.
// Depends on lqr_pkg, lqr_if, lqr_tb_pkg and the block RTL.
`timescale 1ns / 1ps
module lqr_gain_scheduled_torque_test;
  import lqr_pkg::*;
  import lqr_tb_pkg::*;

  logic clk;
  logic rst;
  lqr_in_if  in_ch();
  lqr_out_if out_ch();
  torque_scoreboard sb;
  int  cycles;
  bit  no_idle;
  bit  long_hold;

  lqr_gain_scheduled_torque u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 65536 * 4);
      4: return -$urandom_range(0, 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(in_item_t it);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic load(int s, int g, int t, logic [31:0] v);
    in_item_t it;
    it = '0;
    it.command = CMD_LOAD;
    it.load_set = 3'(s); it.load_gain = 4'(g); it.load_term = 2'(t); it.load_value = v;
    it.theta = $urandom; it.leg_length = 16'($urandom);
    send(it);
  endtask

  task automatic compute(logic [31:0] th, logic [15:0] len);
    in_item_t it;
    it = '0;
    it.command = CMD_COMPUTE;
    it.theta = th; it.leg_length = len;
    it.theta_rate = rnd32(); it.position = rnd32(); it.velocity = rnd32();
    it.pitch = rnd32(); it.pitch_rate = rnd32();
    it.load_set = 3'($urandom); it.load_gain = 4'($urandom); it.load_term = 2'($urandom);
    it.load_value = $urandom;
    send(it);
  endtask

  task automatic load_all(bit big);
    for (int s = 0; s < NUM_SETS; s++)
      for (int g = 0; g < GAINS; g++)
        for (int t = 0; t < TERMS; t++)
          load(s, g, t, big ? rnd32() : $urandom_range(0, 1 << 18) - (1 << 17));
  endtask

  // receiver: random stalls, one long hold-off while the sender has transactions waiting
  initial begin
    int hold;
    out_ch.ready = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 0;
        hold = 0;
        while (hold < 300) begin
          @(negedge clk);
          hold++;
        end
        long_hold = 0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 2)) @(negedge clk);
        out_ch.ready <= 1;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

  initial begin
    logic [31:0] step;
    sb = new();
    no_idle = 0; long_hold = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    rst = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    load_all(0);
    // ignored loads: out-of-range set and gain
    load(7, 3, 0, 32'h12345678);
    load(2, 15, 3, 32'h87654321);
    load(5, 12, 1, 32'hdeadbeef);
    // set boundaries, extremes of theta and leg length
    step = 32'd17157; // about pi/12 in Q16.16
    compute(32'h0, 16'h0);
    compute(32'h80000000, 16'hffff);
    compute(32'h7fffffff, 16'hffff);
    compute(step / 2, 16'h8000);
    compute(step / 2 + 1, 16'h1);
    compute(-(step / 2) - 1, 16'h4000);
    compute(step + step / 2, 16'hffff);
    compute(-(3 * step + step / 2 + 1), 16'h0);
    compute(4 * step, 16'hffff);
    compute(20 * step, 16'h1234);
    // saturating coefficients to force gain overflow and clipped torques
    for (int g = 0; g < GAINS; g++)
      for (int t = 0; t < TERMS; t++) load(0, g, t, t[0] ? 32'h7fffffff : 32'h80000000);
    compute(32'h7fffffff, 16'hffff);
    compute(32'h0, 16'hffff);
    compute(32'h10, 16'h0);

    long_hold = 1;
    for (int n = 0; n < 6; n++) compute($urandom, 16'($urandom));

    for (int n = 0; n < 240; n++) begin
      if (n == 200) no_idle = 1;
      if ($urandom_range(0, 9) == 0)
        load($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 3), rnd32());
      else
        compute($urandom_range(0, 1) ? $urandom : $urandom_range(0, 6 * 17157) *
                ($urandom_range(0, 1) ? 1 : -1), 16'($urandom));
    end
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/lqr_pkg.sv
hw/rtl/lqr_if.sv
hw/rtl/lqr_lane.sv
hw/rtl/lqr_gain_scheduled_torque.sv
hw/rtl/lqr_checker.sv
tb/sv/lqr_tb_if.sv
tb/sv/lqr_gain_scheduled_torque_test.sv
